### rtl/sld_pkg.sv
// Package for the sync/length/checksum deframer.
// Holds frame layout constants, status codes and the result record type.
// No dependencies.
package sld_pkg;

  localparam int MAX_FRAME_DEF = 256;

  localparam logic [7:0] SYNC_BYTE      = 8'hA5;
  localparam int         FRAME_OVERHEAD = 11;
  localparam int         TYPE_POS       = 9;
  localparam int         PAYLOAD_POS    = 10;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_CHECKSUM = 2'd1;
  localparam status_t ST_TYPE     = 2'd2;
  localparam status_t ST_LENGTH   = 2'd3;

  typedef struct packed {
    logic       is_end;
    logic [7:0] payload_byte;
    status_t    frame_status;
  } result_t;

endpackage

### rtl/sld_ifs.sv
// Channel interfaces of the deframer: received bytes, results, configuration.
// Depends on nothing.
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_out_if;
  logic       valid;
  logic       ready;
  logic       is_end;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  modport source (output valid, output is_end, output payload_byte, output frame_status,
                  input ready);
  modport sink   (input valid, input is_end, input payload_byte, input frame_status,
                  output ready);
endinterface

interface sld_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] accepted_type;
  modport source (output valid, output accepted_type, input ready);
  modport sink   (input valid, input accepted_type, output ready);
endinterface

### rtl/sld_in_stage.sv
// Input register of the deframer: holds one received byte until the core takes it.
// Depends on nothing.
module sld_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       step,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;

  assign in_ready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_byte;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

### rtl/sld_core.sv
// Frame state of the deframer: sync hunt, length and type capture, checksum.
// Depends on sld_pkg.
module sld_core #(
  parameter int MAX_FRAME = sld_pkg::MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       accepted_type,
  output logic             has_res,
  output sld_pkg::result_t res
);

  localparam int CntW = $clog2(MAX_FRAME);

  logic            in_frame_r, in_frame_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      type_r, type_nxt;

  logic [15:0]     len_w;
  logic [7:0]      type_w;
  logic            len_bad;
  logic            at_payload;
  logic            at_last;

  always_comb begin
    len_w = len_r;
    if (count_r == CntW'(1)) begin
      len_w = {rx_byte, 8'h00};
    end else if (count_r == CntW'(2)) begin
      len_w = {len_r[15:8], rx_byte};
    end
    type_w     = (count_r == CntW'(sld_pkg::TYPE_POS)) ? rx_byte : type_r;
    len_bad    = ({1'b0, len_w} < 17'(sld_pkg::FRAME_OVERHEAD)) ||
                 (({1'b0, len_w} + 17'(sld_pkg::FRAME_OVERHEAD)) >= 17'(MAX_FRAME));
    at_payload = (count_r >= CntW'(sld_pkg::PAYLOAD_POS));
    at_last    = at_payload && ((17'(count_r) + 17'd1) == {1'b0, len_w});
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    type_nxt     = type_r;
    has_res      = 1'b0;
    res          = '0;
    if (!in_frame_r) begin
      // hunt: drop everything but the sync byte
      if (rx_byte == sld_pkg::SYNC_BYTE) begin
        in_frame_nxt = 1'b1;
        count_nxt    = CntW'(1);
        sum_nxt      = rx_byte;
      end
    end else if (count_r == CntW'(2) && len_bad) begin
      in_frame_nxt     = 1'b0;
      count_nxt        = '0;
      len_nxt          = len_w;
      has_res          = 1'b1;
      res.is_end       = 1'b1;
      res.frame_status = sld_pkg::ST_LENGTH;
    end else if (at_last) begin
      in_frame_nxt = 1'b0;
      count_nxt    = '0;
      has_res      = 1'b1;
      res.is_end   = 1'b1;
      if (sum_r != rx_byte) begin
        res.frame_status = sld_pkg::ST_CHECKSUM;
      end else if (type_r != accepted_type) begin
        res.frame_status = sld_pkg::ST_TYPE;
      end else begin
        res.frame_status = sld_pkg::ST_OK;
      end
    end else begin
      sum_nxt   = sum_r + rx_byte;
      count_nxt = count_r + CntW'(1);
      len_nxt   = len_w;
      type_nxt  = type_w;
      if (at_payload) begin
        has_res          = 1'b1;
        res.payload_byte = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      len_r      <= '0;
      sum_r      <= '0;
      type_r     <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
      type_r     <= type_nxt;
    end
  end

  a_count_tracks_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r == (count_r != '0))
    else $error("position counter out of step with frame flag");

  a_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step && has_res && res.is_end |=> !in_frame_r)
    else $error("still in frame after end result");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step && has_res && !res.is_end |-> in_frame_r && at_payload)
    else $error("payload byte outside payload area");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    has_res && !res.is_end |-> res.frame_status == sld_pkg::ST_OK)
    else $error("payload result carries a status");

endmodule

### rtl/sld_out_stage.sv
// Result register of the deframer: holds one result until the consumer takes it.
// Depends on sld_pkg.
module sld_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sld_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output sld_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  sld_pkg::result_t res_r, res_nxt;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/sync_length_checksum_deframer_top.sv
// Deframer top level: a byte transfer on in_ch passes the input register, then the frame
// logic into the result register, before its result appears on out_ch.
// Throughput 1 byte per cycle, but a byte that yields a result waits while the result register is full.
// Synchronous active-low reset returns to sync hunt, clears both registers and
// sets accepted_type to zero.
module sync_length_checksum_deframer_top #(
  parameter int MAX_FRAME = sld_pkg::MAX_FRAME_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sld_in_if.sink    in_ch,
  sld_out_if.source out_ch,
  sld_cfg_if.sink   cfg_ch
);

  // Configuration register; writes are to arrive only while the block is idle (user's duty, not enforced here)
  logic [7:0] acc_type_r, acc_type_nxt;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             step;
  logic             has_res;
  logic             out_free;
  sld_pkg::result_t core_res;
  sld_pkg::result_t out_res;

  assign cfg_ch.ready = 1'b1;
  assign acc_type_nxt = cfg_ch.valid ? cfg_ch.accepted_type : acc_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_type_r <= '0;
    end else begin
      acc_type_r <= acc_type_nxt;
    end
  end

  // Advance the held byte when it yields no result or the result register has room
  assign step = s1_valid && (!has_res || out_free);

  sld_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .step     (step),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  sld_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_byte       (s1_byte),
    .accepted_type (acc_type_r),
    .has_res       (has_res),
    .res           (core_res)
  );

  // Load a result only on a step that produces one
  sld_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && has_res),
    .res       (core_res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.is_end       = out_res.is_end;
  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.frame_status = out_res.frame_status;

endmodule
